// ===== hw/rtl/multi_pool_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator assertion macros
// Shorthand for the clocked, reset-qualified assertions of the allocator.
// ----------------------------------------------------------------------------
`ifndef MULTI_POOL_BLOCK_ALLOCATOR_MACROS_SVH
`define MULTI_POOL_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpba_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator package
// Payload types, pool interface structs, codes and reset values.
// ----------------------------------------------------------------------------
package mpba_pkg;

  localparam int NUM_POOLS_DEF  = 4;
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int NUM_SIZE_REGS  = 4;

  localparam int SIZE_W    = 16;
  localparam int CNT_W     = 5;
  localparam int BLK_W     = 4;
  localparam int POOL_W    = 2;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int HANDLE_POOLS = 1 << POOL_W;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

  localparam int REG_SIZE0  = 0;
  localparam int REG_COUNT0 = 4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SIZE_W-1:0] request_size;
    logic [POOL_W-1:0] handle_pool;
    logic [BLK_W-1:0]  handle_block;
  } mpba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POOL_W-1:0]   granted_pool;
    logic [BLK_W-1:0]    granted_block;
    logic [CNT_W-1:0]    used_blocks;
    logic [CNT_W-1:0]    peak_blocks;
  } mpba_out_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] peak;
  } mpba_pool_op_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  depth;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  peak;
    logic [BLK_W-1:0]  top;
  } mpba_pool_stat_t;

  function automatic logic [SIZE_W-1:0] size_reset(input int p);
    logic [SIZE_W-1:0] s;
    unique case (p)
      0:       s = 16'd32;
      1:       s = 16'd64;
      2:       s = 16'd128;
      default: s = 16'd256;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/mpba_pool.sv =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator pool
// One pool: size and count registers, free index stack, used and peak counts.
// ----------------------------------------------------------------------------
module mpba_pool import mpba_pkg::*; #(
  parameter int POOL_ID    = 0,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  mpba_pool_op_t        op,
  output mpba_pool_stat_t      stat
);

  localparam int DEPTH_N = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
  localparam int IW      = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1;
  localparam bit HAS_REGS = (POOL_ID < NUM_SIZE_REGS);
  localparam logic [CNT_W-1:0]  CAP       = CNT_W'(DEPTH_N);
  localparam logic [SIZE_W-1:0] SIZE_RST  = size_reset(POOL_ID);
  localparam logic [CNT_W-1:0]  COUNT_RST =
    HAS_REGS ? CNT_W'(16) : CNT_W'((DEPTH_N < 16) ? DEPTH_N : 16);
  localparam logic [CNT_W-1:0]  DEPTH_RST = (COUNT_RST > CAP) ? CAP : COUNT_RST;

  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  depth_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  peak_r;
  logic [BLK_W-1:0]  stack_r [DEPTH_N];

  logic              size_we;
  logic              count_we;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  top_pos;

  assign size_we   = HAS_REGS && cfg_we &&
                     (cfg_index == CFG_IDX_W'(REG_SIZE0 + POOL_ID));
  assign count_we  = HAS_REGS && cfg_we &&
                     (cfg_index == CFG_IDX_W'(REG_COUNT0 + POOL_ID));
  assign count_nxt = cfg_data[CNT_W-1:0];
  assign top_pos   = depth_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RST;
      count_r <= COUNT_RST;
      depth_r <= DEPTH_RST;
      used_r  <= '0;
      peak_r  <= '0;
      for (int k = 0; k < DEPTH_N; k++) begin
        stack_r[k] <= BLK_W'(k);
      end
    end else begin
      if (size_we) begin
        size_r <= cfg_data[SIZE_W-1:0];
      end
      if (count_we) begin
        count_r <= count_nxt;
        depth_r <= (count_nxt > CAP) ? CAP : count_nxt;
        used_r  <= '0;
        peak_r  <= '0;
        for (int k = 0; k < DEPTH_N; k++) begin
          stack_r[k] <= BLK_W'(k);
        end
      end else if (op.pop) begin
        depth_r <= depth_r - 1'b1;
        used_r  <= op.used;
        peak_r  <= op.peak;
      end else if (op.push) begin
        stack_r[depth_r[IW-1:0]] <= op.blk;
        depth_r <= depth_r + 1'b1;
        used_r  <= op.used;
        peak_r  <= op.peak;
      end
    end
  end

  always_comb begin
    stat.size  = size_r;
    stat.cnt   = (count_r > CAP) ? CAP : count_r;
    stat.depth = depth_r;
    stat.used  = used_r;
    stat.peak  = peak_r;
    stat.top   = stack_r[top_pos[IW-1:0]];
  end

endmodule

// ===== hw/rtl/mpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator control
// Pool choice, handle checks, pool updates and result forming for one request.
// ----------------------------------------------------------------------------
module mpba_ctrl import mpba_pkg::*; #(
  parameter int NUM_POOLS = NUM_POOLS_DEF
) (
  input  logic                             exec,
  input  mpba_in_t                         item,
  input  mpba_pool_stat_t [NUM_POOLS-1:0]  stats,
  output mpba_pool_op_t   [NUM_POOLS-1:0]  ops,
  output mpba_out_t                        res
);

  logic             found;
  logic             hp_ok;
  logic [CNT_W-1:0] used_inc;
  logic [CNT_W-1:0] used_dec;
  mpba_pool_stat_t  hstat;

  always_comb begin
    ops      = '0;
    res      = '0;
    found    = 1'b0;
    hp_ok    = 1'b0;
    hstat    = '0;
    used_inc = '0;
    used_dec = '0;

    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p < HANDLE_POOLS && item.handle_pool == POOL_W'(p)) begin
        hstat = stats[p];
        hp_ok = 1'b1;
      end
    end

    unique case (item.command)
      CMD_ALLOC: begin
        res.status = ST_NO_BLOCK;
        for (int p = 0; p < NUM_POOLS; p++) begin
          if (!found && stats[p].size >= item.request_size &&
              stats[p].depth != '0) begin
            found    = 1'b1;
            used_inc = (stats[p].used == CNT_W'(CNT_MAX)) ?
                       stats[p].used : stats[p].used + 1'b1;
            ops[p].pop  = exec;
            ops[p].used = used_inc;
            ops[p].peak = (used_inc > stats[p].peak) ? used_inc : stats[p].peak;
            res.status        = ST_OK;
            res.granted_pool  = POOL_W'(p);
            res.granted_block = stats[p].top;
            res.used_blocks   = used_inc;
            res.peak_blocks   = ops[p].peak;
          end
        end
      end
      CMD_FREE: begin
        res.granted_pool = item.handle_pool;
        if (!hp_ok) begin
          res.status = ST_BAD_HANDLE;
        end else if (CNT_W'(item.handle_block) >= hstat.cnt ||
                     hstat.depth >= hstat.cnt) begin
          res.status      = ST_BAD_HANDLE;
          res.used_blocks = hstat.used;
          res.peak_blocks = hstat.peak;
        end else begin
          used_dec = (hstat.used == '0) ? hstat.used : hstat.used - 1'b1;
          for (int p = 0; p < NUM_POOLS; p++) begin
            if (p < HANDLE_POOLS && item.handle_pool == POOL_W'(p)) begin
              ops[p].push = exec;
              ops[p].blk  = item.handle_block;
              ops[p].used = used_dec;
              ops[p].peak = hstat.peak;
            end
          end
          res.status      = ST_OK;
          res.used_blocks = used_dec;
          res.peak_blocks = hstat.peak;
        end
      end
      default: begin
        res.granted_pool = item.handle_pool;
        if (!hp_ok) begin
          res.status = ST_BAD_HANDLE;
        end else begin
          res.status      = ST_OK;
          res.used_blocks = hstat.used;
          res.peak_blocks = hstat.peak;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/multi_pool_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator
// A request waits in the input register until it fires. Throughput: one
// request per cycle while out_stall is low, set by the single pass from the
// input register through pool choice and stack update to the result register.
// Reset: synchronous; every pool is refilled in the reset cycle itself.
// ----------------------------------------------------------------------------
`include "multi_pool_block_allocator_macros.svh"

module multi_pool_block_allocator import mpba_pkg::*; #(
  parameter int NUM_POOLS  = NUM_POOLS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mpba_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mpba_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic      in_v_r;
  mpba_in_t  in_r;
  logic      out_v_r;
  mpba_out_t out_r;
  logic      fire;
  mpba_out_t res;

  mpba_pool_stat_t [NUM_POOLS-1:0] stats;
  mpba_pool_op_t   [NUM_POOLS-1:0] ops;

  assign fire      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !fire;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
    mpba_pool #(
      .POOL_ID    (p),
      .MAX_BLOCKS (MAX_BLOCKS)
    ) u_pool (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_valid && cfg_ready),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .op        (ops[p]),
      .stat      (stats[p])
    );
  end

  mpba_ctrl #(
    .NUM_POOLS (NUM_POOLS)
  ) u_ctrl (
    .exec  (fire),
    .item  (in_r),
    .stats (stats),
    .ops   (ops),
    .res   (res)
  );

  `MPBA_ASSERT_NXT(a_fire_gives_result, clk, rst_n, fire, out_v_r, "request lost")
  `MPBA_ASSERT_IMP(a_stall_needs_item, clk, rst_n, in_stall, in_v_r, "stall while empty")
  `MPBA_ASSERT_IMP(a_peak_covers_used, clk, rst_n, out_v_r, out_r.peak_blocks >= out_r.used_blocks, "peak below used")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Multi-pool block allocator testbench
// Drives allocate, free and statistics requests through the request channel.
// A scripted opening covers the corner cases, and random traffic then runs
// under several pool layouts. Each result is compared field by field with a
// fixed value or a cycle-free model of four free stacks, used and peak counts.
// Both sides idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mpba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOLS        = NUM_POOLS_DEF;
  localparam int BLOCKS       = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 334;
  localparam int REG_UNUSED   = 9;

  localparam logic [CMD_W-1:0] CMD_STATS     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATS_ALT = 2'd3;

  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [BLK_W-1:0]  blk;
  } handle_t;

  typedef struct {
    mpba_in_t  item;
    bit        known;
    mpba_out_t want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mpba_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mpba_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic [SIZE_W-1:0] blk_size [POOLS];
  logic [CNT_W-1:0]  count_reg [POOLS];
  logic [BLK_W-1:0]  free_blk [POOLS][BLOCKS];
  logic [CNT_W-1:0]  free_depth [POOLS];
  logic [CNT_W-1:0]  in_use [POOLS];
  logic [CNT_W-1:0]  in_use_peak [POOLS];

  mpba_out_t   awaited_results [$];
  handle_t     held_handles [$];
  script_row_t script [$];

  int error_count = 0;
  int cycles = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int phase_size [POOLS];
  int phase_count [POOLS];
  bit phase_poke_spare;

  multi_pool_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int usable_blocks(int p);
    return (count_reg[p] > BLOCKS) ? BLOCKS : int'(count_reg[p]);
  endfunction

  function automatic void refill_pool(int p);
    int n;
    n = usable_blocks(p);
    for (int k = 0; k < BLOCKS; k++) begin
      free_blk[p][k] = (k < n) ? BLK_W'(k) : '0;
    end
    free_depth[p]  = CNT_W'(n);
    in_use[p]      = '0;
    in_use_peak[p] = '0;
  endfunction

  function automatic void reset_pools();
    for (int p = 0; p < POOLS; p++) begin
      blk_size[p]  = size_reset(p);
      count_reg[p] = CNT_W'(BLOCKS);
      refill_pool(p);
    end
  endfunction

  function automatic void apply_reg(int idx, logic [CFG_DAT_W-1:0] val);
    if (idx >= REG_SIZE0 && idx < REG_SIZE0 + POOLS) begin
      blk_size[idx - REG_SIZE0] = val;
    end else if (idx >= REG_COUNT0 && idx < REG_COUNT0 + POOLS) begin
      count_reg[idx - REG_COUNT0] = val[CNT_W-1:0];
      refill_pool(idx - REG_COUNT0);
    end
  endfunction

  // Applies one request to the pool state and returns the result it causes.
  function automatic mpba_out_t serve_request(mpba_in_t item);
    mpba_out_t r;
    int        hp;
    bit        done;
    logic [CNT_W-1:0] d;
    r    = '0;
    hp   = int'(item.handle_pool);
    done = 1'b0;
    if (item.command == CMD_ALLOC) begin
      r.status = ST_NO_BLOCK;
      for (int p = 0; p < POOLS; p++) begin
        if (!done && blk_size[p] >= item.request_size && free_depth[p] != 0) begin
          d             = free_depth[p] - 1'b1;
          free_depth[p] = d;
          if (in_use[p] < CNT_MAX) in_use[p] = in_use[p] + 1'b1;
          if (in_use[p] > in_use_peak[p]) in_use_peak[p] = in_use[p];
          r.status        = ST_OK;
          r.granted_pool  = POOL_W'(p);
          r.granted_block = free_blk[p][d[BLK_W-1:0]];
          r.used_blocks   = in_use[p];
          r.peak_blocks   = in_use_peak[p];
          done            = 1'b1;
        end
      end
    end else begin
      r.granted_pool = item.handle_pool;
      r.status       = ST_OK;
      if (item.command == CMD_FREE) begin
        if (int'(item.handle_block) >= usable_blocks(hp) ||
            int'(free_depth[hp]) >= usable_blocks(hp)) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          free_blk[hp][free_depth[hp][BLK_W-1:0]] = item.handle_block;
          free_depth[hp] = free_depth[hp] + 1'b1;
          if (in_use[hp] != 0) in_use[hp] = in_use[hp] - 1'b1;
        end
      end
      r.used_blocks = in_use[hp];
      r.peak_blocks = in_use_peak[hp];
    end
    return r;
  endfunction

  function automatic mpba_in_t mk_req(logic [CMD_W-1:0] cmd, int bytes, int pool, int blk);
    mpba_in_t r;
    r.command      = cmd;
    r.request_size = SIZE_W'(bytes);
    r.handle_pool  = POOL_W'(pool);
    r.handle_block = BLK_W'(blk);
    return r;
  endfunction

  function automatic mpba_out_t mk_res(logic [STATUS_W-1:0] st, int pool, int blk,
                                       int used, int peak);
    mpba_out_t r;
    r.status        = st;
    r.granted_pool  = POOL_W'(pool);
    r.granted_block = BLK_W'(blk);
    r.used_blocks   = CNT_W'(used);
    r.peak_blocks   = CNT_W'(peak);
    return r;
  endfunction

  function automatic void add_row(mpba_in_t item, bit known, mpba_out_t want);
    script_row_t row;
    row.item  = item;
    row.known = known;
    row.want  = want;
    script.push_back(row);
  endfunction

  function automatic mpba_in_t next_request();
    mpba_in_t r;
    int       pick;
    int       sel;
    handle_t  h;
    r.command      = CMD_ALLOC;
    r.request_size = SIZE_W'($urandom);
    r.handle_pool  = POOL_W'($urandom);
    r.handle_block = BLK_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      sel = $urandom_range(0, POOLS - 1);
      case ($urandom_range(0, 5))
        0:       ;
        1:       r.request_size = '0;
        4:       r.request_size = blk_size[sel] + 1'b1;
        5:       r.request_size = blk_size[sel] - 1'b1;
        default: r.request_size = blk_size[sel];
      endcase
    end else if (pick < 85 && held_handles.size() != 0) begin
      sel            = $urandom_range(0, held_handles.size() - 1);
      h              = held_handles[sel];
      held_handles.delete(sel);
      r.command      = CMD_FREE;
      r.handle_pool  = h.pool;
      r.handle_block = h.blk;
    end else if (pick < 93) begin
      r.command = CMD_FREE;
    end else begin
      r.command = $urandom_range(0, 1) ? CMD_STATS : CMD_STATS_ALT;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] ERROR %s", $time, what);
    error_count++;
  endtask

  task automatic compare_result(mpba_out_t got, mpba_out_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.granted_pool !== want.granted_pool)
      report_mismatch($sformatf("granted_pool got %0d want %0d",
                                got.granted_pool, want.granted_pool));
    if (got.granted_block !== want.granted_block)
      report_mismatch($sformatf("granted_block got %0d want %0d",
                                got.granted_block, want.granted_block));
    if (got.used_blocks !== want.used_blocks)
      report_mismatch($sformatf("used_blocks got %0d want %0d",
                                got.used_blocks, want.used_blocks));
    if (got.peak_blocks !== want.peak_blocks)
      report_mismatch($sformatf("peak_blocks got %0d want %0d",
                                got.peak_blocks, want.peak_blocks));
  endtask

  task automatic issue(mpba_in_t item, bit known, mpba_out_t want);
    mpba_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = serve_request(item);
    if (item.command == CMD_ALLOC && predicted.status == ST_OK)
      held_handles.push_back({predicted.granted_pool, predicted.granted_block});
    awaited_results.push_back(known ? want : predicted);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(int idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= CFG_DAT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, CFG_DAT_W'(val));
  endtask

  task automatic program_pools();
    for (int p = 0; p < POOLS; p++) put_reg(REG_SIZE0 + p, phase_size[p]);
    for (int p = 0; p < POOLS; p++) put_reg(REG_COUNT0 + p, phase_count[p]);
    if (phase_poke_spare) put_reg(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    held_handles.delete();
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: %h", out_data));
      end else begin
        compare_result(out_data, awaited_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[%0t] ERROR timeout with %0d results outstanding",
               $time, awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_pools();

    add_row(mk_req(CMD_STATS, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 0, 0));
    add_row(mk_req(CMD_FREE, 0, 0, 0), 1, mk_res(ST_BAD_HANDLE, 0, 0, 0, 0));
    add_row(mk_req(CMD_ALLOC, 0, 0, 0), 1, mk_res(ST_OK, 0, 15, 1, 1));
    add_row(mk_req(CMD_ALLOC, 65535, 3, 15), 1, mk_res(ST_NO_BLOCK, 0, 0, 0, 0));
    add_row(mk_req(CMD_ALLOC, 33, 0, 0), 1, mk_res(ST_OK, 1, 15, 1, 1));
    add_row(mk_req(CMD_ALLOC, 256, 0, 0), 1, mk_res(ST_OK, 3, 15, 1, 1));
    add_row(mk_req(CMD_ALLOC, 257, 0, 0), 1, mk_res(ST_NO_BLOCK, 0, 0, 0, 0));
    add_row(mk_req(CMD_FREE, 0, 0, 15), 1, mk_res(ST_OK, 0, 0, 0, 1));
    add_row(mk_req(CMD_FREE, 0, 0, 15), 1, mk_res(ST_BAD_HANDLE, 0, 0, 0, 1));
    add_row(mk_req(CMD_STATS_ALT, 0, 3, 0), 1, mk_res(ST_OK, 3, 0, 1, 1));
    add_row(mk_req(CMD_STATS, 65535, 1, 15), 1, mk_res(ST_OK, 1, 0, 1, 1));
    add_row(mk_req(CMD_ALLOC, 32, 0, 0), 0, '0);
    add_row(mk_req(CMD_ALLOC, 32, 0, 0), 0, '0);
    add_row(mk_req(CMD_ALLOC, 128, 0, 0), 0, '0);
    add_row(mk_req(CMD_FREE, 0, 1, 15), 0, '0);
    add_row(mk_req(CMD_FREE, 0, 2, 3), 0, '0);
    add_row(mk_req(CMD_ALLOC, 64, 0, 0), 0, '0);
    add_row(mk_req(CMD_ALLOC, 65, 0, 0), 0, '0);
    add_row(mk_req(CMD_STATS_ALT, 0, 2, 0), 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        phase_poke_spare = 1'b0;
        case (ph)
          1: begin
            phase_size  = '{16, 48, 200, 65535};
            phase_count = '{1, 2, 3, 16};
          end
          2: begin
            phase_size  = '{1, 1, 65535, 65535};
            phase_count = '{0, 16, 0, 5};
          end
          3: begin
            phase_size       = '{65535, 1000, 100, 10};
            phase_count      = '{4, 16, 16, 16};
            phase_poke_spare = 1'b1;
          end
          4: begin
            for (int p = 0; p < POOLS; p++) begin
              phase_size[p]  = $urandom_range(1, 65535);
              phase_count[p] = $urandom_range(0, BLOCKS);
            end
          end
          default: begin
            phase_size  = '{32, 64, 128, 256};
            phase_count = '{16, 16, 16, 16};
          end
        endcase
        program_pools();
      end

      case (ph % 3)
        0: begin
          sender_gap_pct     = 10;
          receiver_stall_pct = 81;
        end
        1: begin
          sender_gap_pct     = 81;
          receiver_stall_pct = 10;
        end
        default: begin
          sender_gap_pct     = 0;
          receiver_stall_pct = 0;
        end
      endcase

      if (ph == 0) begin
        foreach (script[i]) issue(script[i].item, script[i].known, script[i].want);
        drain_results();
      end

      for (int n = 0; n < PHASE_ITEMS; n++) issue(next_request(), 1'b0, '0);
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
